// ----- rtl/itf_pkg.sv -----
// itf_pkg: types, constants and helper functions for the integer-to-text formatter
// used by itf_step_unit, itf_digit_mem and integer_to_text_formatter_unit
// no dependencies
package itf_pkg;

	// value and conversion geometry
	localparam int VALUE_W = 64;
	localparam int HALF_W = VALUE_W / 2;
	localparam int CHUNK_W = 8;
	localparam int NCHUNK = VALUE_W / CHUNK_W;
	localparam int STEP_W = $clog2(NCHUNK);
	localparam int MINW_W = 6;
	localparam int DIGIT_DEPTH_DEF = 32;

	// ascii codes
	localparam logic [7:0] CH_SPACE = 8'h20;
	localparam logic [7:0] CH_PLUS = 8'h2B;
	localparam logic [7:0] CH_MINUS = 8'h2D;
	localparam logic [7:0] CH_ZERO = 8'h30;
	localparam logic [7:0] CH_X_UP = 8'h58;
	localparam logic [7:0] CH_X_LO = 8'h78;
	localparam logic [7:0] CH_A_UP = 8'h41;
	localparam logic [7:0] CH_A_LO = 8'h61;

	// conversion kinds
	typedef enum logic [1:0] {
		KIND_UDEC = 2'd0,
		KIND_SDEC = 2'd1,
		KIND_HEX  = 2'd2,
		KIND_OCT  = 2'd3
	} kind_t;

	// sequencer states
	typedef enum logic [3:0] {
		ST_IDLE,
		ST_CONV,
		ST_PREFIX,
		ST_SIZE,
		ST_PAD_SP,
		ST_SIGN,
		ST_PAD_ZERO,
		ST_DREAD,
		ST_DOUT
	} state_t;

	// input item
	typedef struct packed {
		kind_t kind;
		logic [VALUE_W-1:0] value;
		logic wide;
		logic upper_case;
		logic alternate;
		logic zero_pad;
		logic space_sign;
		logic plus_sign;
		logic [MINW_W-1:0] min_width;
	} cmd_t;

	// result item
	typedef struct packed {
		logic [7:0] out_char;
		logic last;
	} txt_t;

	// one step of the shared conversion unit
	typedef struct packed {
		logic [VALUE_W-1:0] work;
		logic [3:0] rem;
		logic [3:0] digit;
	} step_res_t;

	// digit value to ascii, hex letters in either case
	function automatic logic [7:0] digit_char(input logic [3:0] d, input logic upper);
		logic [7:0] base;
		if (d < 4'd10) begin
			return CH_ZERO + {4'b0, d};
		end
		base = upper ? CH_A_UP : CH_A_LO;
		return base + {4'b0, d} - 8'd10;
	endfunction

endpackage

// ----- rtl/integer_to_text_formatter_unit.sv -----
// integer_to_text_formatter_unit: printf style integer formatter, top level
// depends on itf_pkg, itf_step_unit and itf_digit_mem
//
// One item is taken while the block is idle (cmd_stall low) and leaves as a
// run of ascii characters on txt, the final one marked by last. Digits are
// produced least significant first by one shared step unit: a hex or octal
// digit each cycle, or a decimal digit by long division by ten (eight bits per
// cycle over the 64-bit word), and stored in a small digit memory, followed
// by up to two prefix characters. Then come a sizing state, the pad and sign
// characters and, for each digit, a memory read and then its output. Stalls
// on txt hold the pad, sign and digit output.
// cmd_stall stays high until the last character sits in the output register.
module integer_to_text_formatter_unit #(
	parameter int DIGIT_BUFFER_DEPTH = itf_pkg::DIGIT_DEPTH_DEF
) (
	input logic clk,
	input logic arst_n,
	input logic cmd_valid,
	output logic cmd_stall,
	input itf_pkg::cmd_t cmd,
	output logic txt_valid,
	input logic txt_stall,
	output itf_pkg::txt_t txt
);

	localparam int AW = $clog2(DIGIT_BUFFER_DEPTH);
	localparam int CW = $clog2(DIGIT_BUFFER_DEPTH + 1);
	localparam int NW = (CW > itf_pkg::MINW_W ? CW : itf_pkg::MINW_W) + 1;
	localparam int VW = itf_pkg::VALUE_W;
	localparam int HW = itf_pkg::HALF_W;

	itf_pkg::state_t state_q, state_nxt;
	itf_pkg::kind_t kind_q;
	logic upper_q, alt_q, zpad_q, nonzero_q, has_sign_q, pfx_q;
	logic [7:0] sign_char_q;
	logic [itf_pkg::MINW_W-1:0] minw_q;
	logic [VW-1:0] work_q;
	logic [3:0] rem_q;
	logic [itf_pkg::STEP_W-1:0] step_q;
	logic [CW-1:0] digit_count_q;
	logic [itf_pkg::MINW_W-1:0] pad_count_q;
	logic [AW-1:0] rd_idx_q;
	logic txt_valid_q;
	itf_pkg::txt_t txt_q;

	logic accept;
	logic out_free;
	logic [VW-1:0] v_in, v_neg, v_mag;
	logic neg_in, sdec_in;
	itf_pkg::step_res_t step_res;
	logic digit_done, conv_end, pfx_any, pfx_end, room;
	logic wr_en, emit_en, emit_last;
	logic [7:0] wr_char, emit_char, rd_char;
	logic [NW-1:0] need_w, minw_w;
	logic [itf_pkg::MINW_W-1:0] pad_calc;
	logic radix_pow2;

	assign accept = cmd_valid && !cmd_stall;
	assign cmd_stall = (state_q != itf_pkg::ST_IDLE);
	assign out_free = !txt_valid_q || !txt_stall;
	assign txt_valid = txt_valid_q;
	assign txt = txt_q;

	// magnitude and sign of the incoming value
	always_comb begin
		v_in = cmd.wide ? cmd.value : {{HW{1'b0}}, cmd.value[HW-1:0]};
		v_neg = '0 - v_in;
		sdec_in = (cmd.kind == itf_pkg::KIND_SDEC);
		neg_in = sdec_in && (cmd.wide ? v_in[VW-1] : v_in[HW-1]);
		if (!neg_in) begin
			v_mag = v_in;
		end else if (cmd.wide) begin
			v_mag = v_neg;
		end else begin
			v_mag = {{HW{1'b0}}, v_neg[HW-1:0]};
		end
	end

	// shared conversion unit
	itf_step_unit u_step (
		.kind(kind_q),
		.work(work_q),
		.rem(rem_q),
		.res(step_res)
	);

	// digit store
	itf_digit_mem #(
		.DEPTH(DIGIT_BUFFER_DEPTH)
	) u_mem (
		.clk(clk),
		.wr_en(wr_en),
		.wr_addr(digit_count_q[AW-1:0]),
		.wr_data(wr_char),
		.rd_addr(rd_idx_q),
		.rd_data(rd_char)
	);

	// field sizing
	always_comb begin
		need_w = NW'(digit_count_q) + NW'(has_sign_q);
		minw_w = NW'(minw_q);
		pad_calc = (minw_w > need_w) ? itf_pkg::MINW_W'(minw_w - need_w) : '0;
	end

	// datapath controls for the current state
	always_comb begin
		radix_pow2 = (kind_q == itf_pkg::KIND_HEX) || (kind_q == itf_pkg::KIND_OCT);
		room = (digit_count_q < CW'(DIGIT_BUFFER_DEPTH));
		digit_done = radix_pow2 || (step_q == itf_pkg::STEP_W'(itf_pkg::NCHUNK - 1));
		conv_end = digit_done && (step_res.work == '0);
		pfx_any = alt_q && nonzero_q && radix_pow2;
		pfx_end = !pfx_any || (kind_q == itf_pkg::KIND_OCT) || pfx_q;
		wr_en = 1'b0;
		wr_char = itf_pkg::CH_ZERO;
		emit_en = 1'b0;
		emit_char = itf_pkg::CH_SPACE;
		emit_last = 1'b0;
		unique case (state_q)
			itf_pkg::ST_CONV: begin
				wr_en = digit_done && room;
				wr_char = itf_pkg::digit_char(step_res.digit, upper_q);
			end
			itf_pkg::ST_PREFIX: begin
				wr_en = pfx_any && room;
				if (kind_q == itf_pkg::KIND_HEX && !pfx_q) begin
					wr_char = upper_q ? itf_pkg::CH_X_UP : itf_pkg::CH_X_LO;
				end
			end
			itf_pkg::ST_PAD_SP: begin
				emit_en = out_free;
			end
			itf_pkg::ST_SIGN: begin
				emit_en = out_free;
				emit_char = sign_char_q;
			end
			itf_pkg::ST_PAD_ZERO: begin
				emit_en = out_free;
				emit_char = itf_pkg::CH_ZERO;
			end
			itf_pkg::ST_DOUT: begin
				emit_en = out_free;
				emit_char = rd_char;
				emit_last = (rd_idx_q == '0);
			end
			default: begin
			end
		endcase
	end

	// next state
	always_comb begin
		state_nxt = state_q;
		unique case (state_q)
			itf_pkg::ST_IDLE: begin
				if (accept) begin
					state_nxt = itf_pkg::ST_CONV;
				end
			end
			itf_pkg::ST_CONV: begin
				if (conv_end) begin
					state_nxt = itf_pkg::ST_PREFIX;
				end
			end
			itf_pkg::ST_PREFIX: begin
				if (pfx_end) begin
					state_nxt = itf_pkg::ST_SIZE;
				end
			end
			itf_pkg::ST_SIZE: begin
				if (!zpad_q && pad_calc != '0) begin
					state_nxt = itf_pkg::ST_PAD_SP;
				end else if (has_sign_q) begin
					state_nxt = itf_pkg::ST_SIGN;
				end else if (zpad_q && pad_calc != '0) begin
					state_nxt = itf_pkg::ST_PAD_ZERO;
				end else begin
					state_nxt = itf_pkg::ST_DREAD;
				end
			end
			itf_pkg::ST_PAD_SP: begin
				if (out_free && pad_count_q == itf_pkg::MINW_W'(1)) begin
					state_nxt = has_sign_q ? itf_pkg::ST_SIGN : itf_pkg::ST_DREAD;
				end
			end
			itf_pkg::ST_SIGN: begin
				if (out_free) begin
					state_nxt = (zpad_q && pad_count_q != '0) ? itf_pkg::ST_PAD_ZERO
						: itf_pkg::ST_DREAD;
				end
			end
			itf_pkg::ST_PAD_ZERO: begin
				if (out_free && pad_count_q == itf_pkg::MINW_W'(1)) begin
					state_nxt = itf_pkg::ST_DREAD;
				end
			end
			itf_pkg::ST_DREAD: begin
				state_nxt = itf_pkg::ST_DOUT;
			end
			itf_pkg::ST_DOUT: begin
				if (out_free) begin
					state_nxt = (rd_idx_q == '0) ? itf_pkg::ST_IDLE : itf_pkg::ST_DREAD;
				end
			end
			default: begin
				state_nxt = itf_pkg::ST_IDLE;
			end
		endcase
	end

	// sequencer and counters
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= itf_pkg::ST_IDLE;
			work_q <= '0;
			rem_q <= '0;
			step_q <= '0;
			digit_count_q <= '0;
			pad_count_q <= '0;
			rd_idx_q <= '0;
			pfx_q <= 1'b0;
		end else begin
			state_q <= state_nxt;
			if (accept) begin
				work_q <= v_mag;
				rem_q <= '0;
				step_q <= '0;
				digit_count_q <= '0;
				pfx_q <= 1'b0;
			end
			if (state_q == itf_pkg::ST_CONV) begin
				work_q <= step_res.work;
				rem_q <= digit_done ? 4'd0 : step_res.rem;
				step_q <= step_q + 1'b1;
			end
			if (state_q == itf_pkg::ST_PREFIX) begin
				pfx_q <= 1'b1;
			end
			if (wr_en) begin
				digit_count_q <= digit_count_q + 1'b1;
			end
			if (state_q == itf_pkg::ST_SIZE) begin
				pad_count_q <= pad_calc;
				rd_idx_q <= AW'(digit_count_q - 1'b1);
			end
			if (emit_en && (state_q == itf_pkg::ST_PAD_SP
					|| state_q == itf_pkg::ST_PAD_ZERO)) begin
				pad_count_q <= pad_count_q - 1'b1;
			end
			if (emit_en && state_q == itf_pkg::ST_DOUT && rd_idx_q != '0) begin
				rd_idx_q <= rd_idx_q - 1'b1;
			end
		end
	end

	// per-item options, loaded on accept
	always_ff @(posedge clk) begin
		if (accept) begin
			kind_q <= cmd.kind;
			upper_q <= cmd.upper_case;
			alt_q <= cmd.alternate;
			zpad_q <= cmd.zero_pad;
			minw_q <= cmd.min_width;
			nonzero_q <= (v_mag != '0);
			has_sign_q <= neg_in || (sdec_in && (cmd.space_sign || cmd.plus_sign));
			if (neg_in) begin
				sign_char_q <= itf_pkg::CH_MINUS;
			end else if (cmd.space_sign) begin
				sign_char_q <= itf_pkg::CH_SPACE;
			end else begin
				sign_char_q <= itf_pkg::CH_PLUS;
			end
		end
	end

	// output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			txt_valid_q <= 1'b0;
		end else if (emit_en) begin
			txt_valid_q <= 1'b1;
		end else if (!txt_stall) begin
			txt_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (emit_en) begin
			txt_q.out_char <= emit_char;
			txt_q.last <= emit_last;
		end
	end

	// an accepted item always starts the conversion
	a_accept_conv: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> state_q == itf_pkg::ST_CONV)
		else $error("accepted item did not start conversion");

	// the digit count never runs past the store
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		digit_count_q <= CW'(DIGIT_BUFFER_DEPTH))
		else $error("digit count beyond store depth");

	// sizing always sees at least one stored digit
	a_size_digits: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itf_pkg::ST_SIZE |-> digit_count_q != '0)
		else $error("no digit stored before sizing");

	// last is marked exactly on the digit read from the bottom of the store
	a_last_mark: assert property (@(posedge clk) disable iff (!arst_n)
		emit_en |=> txt.last == ($past(state_q) == itf_pkg::ST_DOUT
			&& $past(rd_idx_q) == '0))
		else $error("last mark on wrong character");

	// padding ends before the digit reads start
	a_pad_done: assert property (@(posedge clk) disable iff (!arst_n)
		state_q == itf_pkg::ST_DREAD |-> pad_count_q == '0 || $past(state_q) == itf_pkg::ST_DOUT
			|| $past(state_q) == itf_pkg::ST_SIZE)
		else $error("digits started with padding left");

endmodule

// ----- rtl/itf_step_unit.sv -----
// itf_step_unit: shared conversion step, one hex or octal digit, or eight
// bits of the long division by ten for decimal
// depends on itf_pkg
module itf_step_unit (
	input itf_pkg::kind_t kind,
	input logic [itf_pkg::VALUE_W-1:0] work,
	input logic [3:0] rem,
	output itf_pkg::step_res_t res
);

	logic [itf_pkg::CHUNK_W-1:0] chunk;
	logic [itf_pkg::CHUNK_W-1:0] quo;
	logic [3:0] r;
	logic [4:0] t;

	// restoring division by ten over the top chunk, remainder stays below ten
	always_comb begin
		chunk = work[itf_pkg::VALUE_W-1 -: itf_pkg::CHUNK_W];
		r = rem;
		t = '0;
		quo = '0;
		for (int i = itf_pkg::CHUNK_W - 1; i >= 0; i--) begin
			t = {r, chunk[i]};
			if (t >= 5'd10) begin
				quo[i] = 1'b1;
				r = 4'(t - 5'd10);
			end else begin
				quo[i] = 1'b0;
				r = t[3:0];
			end
		end
	end

	// select the step for the conversion kind
	always_comb begin
		unique case (kind) inside
			itf_pkg::KIND_HEX: begin
				res.work = work >> 4;
				res.rem = rem;
				res.digit = work[3:0];
			end
			itf_pkg::KIND_OCT: begin
				res.work = work >> 3;
				res.rem = rem;
				res.digit = {1'b0, work[2:0]};
			end
			itf_pkg::KIND_UDEC, itf_pkg::KIND_SDEC: begin
				res.work = {work[itf_pkg::VALUE_W-itf_pkg::CHUNK_W-1:0], quo};
				res.rem = r;
				res.digit = r;
			end
			default: begin
				res.work = work;
				res.rem = rem;
				res.digit = '0;
			end
		endcase
	end

endmodule

// ----- rtl/itf_digit_mem.sv -----
// itf_digit_mem: digit character store, one write and one registered read port
// depends on itf_pkg only through the default depth
module itf_digit_mem #(
	parameter int DEPTH = itf_pkg::DIGIT_DEPTH_DEF
) (
	input logic clk,
	input logic wr_en,
	input logic [$clog2(DEPTH)-1:0] wr_addr,
	input logic [7:0] wr_data,
	input logic [$clog2(DEPTH)-1:0] rd_addr,
	output logic [7:0] rd_data
);

	logic [7:0] mem_q [DEPTH];
	logic [7:0] rd_data_q;

	// write port
	always_ff @(posedge clk) begin
		if (wr_en) begin
			mem_q[wr_addr] <= wr_data;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rd_data_q <= mem_q[rd_addr];
	end

	assign rd_data = rd_data_q;

endmodule

// ----- sim/integer_to_text_formatter_unit_tb.sv -----
// integer_to_text_formatter_unit_tb: self-checking bench for the integer-to-text formatter
// a scoreboard class predicts each formatted number as a queue of characters
// depends on itf_pkg and integer_to_text_formatter_unit
module integer_to_text_formatter_unit_tb;

	localparam int MAX_CHARS = 63;
	localparam int CYCLE_LIMIT = 1000000;
	localparam int DRAIN_CYCLES = 300;
	localparam int HOLD_CYCLES = 400;
	localparam int RAND_PER_PHASE = 62;
	localparam string DIGITS_UP = "0123456789ABCDEF";
	localparam string DIGITS_LO = "0123456789abcdef";

	// predicts the characters of each accepted number and checks them in order
	class char_scoreboard;
		itf_pkg::txt_t expected_chars[$];
		int mismatches = 0;

		function void note_number(itf_pkg::cmd_t c);
			logic [63:0] mag;
			logic [7:0] sign_ch;
			logic [7:0] digits[$];
			logic [7:0] line[$];
			string tab;
			int need;
			int pad;
			itf_pkg::txt_t t;
			tab = c.upper_case ? DIGITS_UP : DIGITS_LO;
			mag = c.wide ? c.value : {32'h0, c.value[31:0]};
			sign_ch = 8'h00;
			// sign handling only for signed decimal, space beats plus
			if (c.kind == itf_pkg::KIND_SDEC) begin
				if (c.wide ? mag[63] : mag[31]) begin
					mag = -mag;
					if (!c.wide) mag[63:32] = 32'h0;
					sign_ch = itf_pkg::CH_MINUS;
				end else if (c.space_sign) begin
					sign_ch = itf_pkg::CH_SPACE;
				end else if (c.plus_sign) begin
					sign_ch = itf_pkg::CH_PLUS;
				end
			end
			// digits least significant first, prefix last
			if (mag == 64'h0) begin
				digits.push_back(itf_pkg::CH_ZERO);
			end else begin
				case (c.kind)
					itf_pkg::KIND_HEX: begin
						while (mag != 64'h0) begin
							digits.push_back(tab[int'(mag[3:0])]);
							mag = mag >> 4;
						end
						if (c.alternate) begin
							digits.push_back(c.upper_case ? itf_pkg::CH_X_UP
								: itf_pkg::CH_X_LO);
							digits.push_back(itf_pkg::CH_ZERO);
						end
					end
					itf_pkg::KIND_OCT: begin
						while (mag != 64'h0) begin
							digits.push_back(tab[int'(mag[2:0])]);
							mag = mag >> 3;
						end
						if (c.alternate) digits.push_back(itf_pkg::CH_ZERO);
					end
					default: begin
						while (mag != 64'h0) begin
							digits.push_back(tab[int'(mag % 64'd10)]);
							mag = mag / 64'd10;
						end
					end
				endcase
			end
			// space pad, sign, zero pad, then digits most significant first
			need = digits.size() + ((sign_ch != 8'h00) ? 1 : 0);
			pad = (int'(c.min_width) > need) ? int'(c.min_width) - need : 0;
			if (!c.zero_pad) repeat (pad) line.push_back(itf_pkg::CH_SPACE);
			if (sign_ch != 8'h00) line.push_back(sign_ch);
			if (c.zero_pad) repeat (pad) line.push_back(itf_pkg::CH_ZERO);
			for (int i = digits.size() - 1; i >= 0; i--) line.push_back(digits[i]);
			while (line.size() > MAX_CHARS) line.pop_back();
			foreach (line[i]) begin
				t.out_char = line[i];
				t.last = (i == line.size() - 1);
				expected_chars.push_back(t);
			end
		endfunction

		function void check_char(itf_pkg::txt_t got);
			itf_pkg::txt_t want;
			if (expected_chars.size() == 0) begin
				$error("unexpected item out_char=%h last=%b", got.out_char, got.last);
				mismatches++;
				return;
			end
			want = expected_chars.pop_front();
			if (got.out_char !== want.out_char) begin
				$error("out_char expected %h actual %h", want.out_char, got.out_char);
				mismatches++;
			end
			if (got.last !== want.last) begin
				$error("last expected %b actual %b", want.last, got.last);
				mismatches++;
			end
		endfunction
	endclass

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cmd_valid = 1'b0;
	logic cmd_stall;
	itf_pkg::cmd_t cmd = '0;
	logic txt_valid;
	logic txt_stall = 1'b0;
	itf_pkg::txt_t txt;

	char_scoreboard sb = new();
	int send_idle_pct = 0;
	int recv_stall_pct = 0;
	logic hold_trig = 1'b0;
	logic hold_done = 1'b0;
	int hold_cnt = 0;
	int cycles = 0;

	integer_to_text_formatter_unit dut (
		.clk(clk),
		.arst_n(arst_n),
		.cmd_valid(cmd_valid),
		.cmd_stall(cmd_stall),
		.cmd(cmd),
		.txt_valid(txt_valid),
		.txt_stall(txt_stall),
		.txt(txt)
	);

	always #5 clk = ~clk;

	// run limit
	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles > CYCLE_LIMIT) begin
			$display("TEST FAILED");
			$finish;
		end
	end

	// receiver: check accepted characters, random stall plus one long hold-off
	always @(posedge clk) begin
		if (arst_n && txt_valid && !txt_stall) sb.check_char(txt);
		if (hold_cnt != 0) begin
			txt_stall <= 1'b1;
			hold_cnt <= hold_cnt - 1;
		end else if (hold_trig && !hold_done) begin
			txt_stall <= 1'b1;
			hold_cnt <= HOLD_CYCLES;
			hold_done <= 1'b1;
		end else begin
			txt_stall <= ($urandom_range(99) < recv_stall_pct);
		end
	end

	function automatic itf_pkg::cmd_t make_cmd(itf_pkg::kind_t k, logic [63:0] v, logic w,
			logic up, logic alt, logic zp, logic sp, logic pl, logic [5:0] mw);
		itf_pkg::cmd_t c;
		c.kind = k;
		c.value = v;
		c.wide = w;
		c.upper_case = up;
		c.alternate = alt;
		c.zero_pad = zp;
		c.space_sign = sp;
		c.plus_sign = pl;
		c.min_width = mw;
		return c;
	endfunction

	// values biased toward sign boundaries, short numbers and full width
	function automatic logic [63:0] rand_value();
		logic [63:0] v;
		v = {$urandom, $urandom};
		case ($urandom_range(5))
			0: v = v;
			1: v = 64'($urandom_range(1000));
			2: v = v >> $urandom_range(63);
			3: begin
				case ($urandom_range(5))
					0: v = 64'h0;
					1: v = 64'h7FFF_FFFF;
					2: v = 64'h8000_0000;
					3: v = 64'hFFFF_FFFF;
					4: v = 64'h8000_0000_0000_0000;
					default: v = 64'hFFFF_FFFF_FFFF_FFFF;
				endcase
				if ($urandom_range(1)) v[63:32] = $urandom;
			end
			4: v = v | 64'h8000_0000_8000_0000;
			default: v = {$urandom, 32'h0} | 64'($urandom_range(255));
		endcase
		return v;
	endfunction

	function automatic itf_pkg::cmd_t rand_cmd();
		itf_pkg::cmd_t c;
		c.kind = itf_pkg::kind_t'($urandom_range(3));
		c.value = rand_value();
		c.wide = 1'($urandom_range(1));
		c.upper_case = 1'($urandom_range(1));
		c.alternate = 1'($urandom_range(1));
		c.zero_pad = 1'($urandom_range(1));
		c.space_sign = 1'($urandom_range(1));
		c.plus_sign = 1'($urandom_range(1));
		c.min_width = $urandom_range(1) ? 6'($urandom_range(24)) : 6'($urandom_range(63));
		return c;
	endfunction

	// offer one item after random idle cycles, hold it until accepted
	task automatic send_cmd(input itf_pkg::cmd_t c);
		while ($urandom_range(99) < send_idle_pct) begin
			cmd_valid <= 1'b0;
			@(posedge clk);
		end
		cmd <= c;
		cmd_valid <= 1'b1;
		do @(posedge clk); while (!(cmd_valid && !cmd_stall));
		sb.note_number(c);
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// sender idles little, receiver stalls often
		send_idle_pct = 12;
		recv_stall_pct <= 57;

		// directed numbers
		send_cmd(make_cmd(itf_pkg::KIND_UDEC, 64'h0,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0));
		send_cmd(make_cmd(itf_pkg::KIND_UDEC, 64'hA5A5_A5A5_FFFF_FFFF,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0));
		send_cmd(make_cmd(itf_pkg::KIND_UDEC, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0));
		send_cmd(make_cmd(itf_pkg::KIND_SDEC, 64'h8000_0000,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd0));
		send_cmd(make_cmd(itf_pkg::KIND_SDEC, 64'h8000_0000_0000_0000,
			1'b1, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 6'd25));
		send_cmd(make_cmd(itf_pkg::KIND_SDEC, 64'h0,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 6'd0));
		send_cmd(make_cmd(itf_pkg::KIND_SDEC, 64'h0,
			1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd4));
		send_cmd(make_cmd(itf_pkg::KIND_SDEC, 64'd5,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 6'd3));
		send_cmd(make_cmd(itf_pkg::KIND_SDEC, 64'hFFFF_FFFF,
			1'b0, 1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 6'd10));
		send_cmd(make_cmd(itf_pkg::KIND_SDEC, 64'd123,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd3));
		send_cmd(make_cmd(itf_pkg::KIND_SDEC, 64'hFFFF_FFFF_FFFF_FFD6,
			1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd8));
		send_cmd(make_cmd(itf_pkg::KIND_HEX, 64'hDEAD_BEEF,
			1'b0, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 6'd20));
		send_cmd(make_cmd(itf_pkg::KIND_HEX, 64'hFEDC_BA98_7654_3210,
			1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0));
		send_cmd(make_cmd(itf_pkg::KIND_HEX, 64'h0,
			1'b1, 1'b1, 1'b1, 1'b1, 1'b0, 1'b0, 6'd0));
		send_cmd(make_cmd(itf_pkg::KIND_HEX, 64'hABC,
			1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b1, 6'd63));
		send_cmd(make_cmd(itf_pkg::KIND_OCT, 64'hFFFF_FFFF_FFFF_FFFF,
			1'b1, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0));
		send_cmd(make_cmd(itf_pkg::KIND_OCT, 64'd8,
			1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd0));
		send_cmd(make_cmd(itf_pkg::KIND_OCT, 64'h0,
			1'b0, 1'b0, 1'b1, 1'b0, 1'b0, 1'b0, 6'd2));
		send_cmd(make_cmd(itf_pkg::KIND_OCT, 64'hFFFF_FFFF,
			1'b0, 1'b1, 1'b0, 1'b1, 1'b1, 1'b0, 6'd63));
		send_cmd(make_cmd(itf_pkg::KIND_UDEC, 64'd12345,
			1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 1'b1, 6'd63));
		send_cmd(make_cmd(itf_pkg::KIND_UDEC, 64'd1,
			1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b0, 6'd1));
		send_cmd(make_cmd(itf_pkg::KIND_SDEC, 64'h7FFF_FFFF_FFFF_FFFF,
			1'b1, 1'b0, 1'b0, 1'b0, 1'b0, 1'b1, 6'd63));

		repeat (RAND_PER_PHASE) send_cmd(rand_cmd());

		// sender idles often, receiver stalls little
		send_idle_pct = 57;
		recv_stall_pct <= 12;
		repeat (RAND_PER_PHASE) send_cmd(rand_cmd());

		// no idling, one long receiver hold-off while items keep coming
		send_idle_pct = 0;
		recv_stall_pct <= 0;
		hold_trig <= 1'b1;
		repeat (RAND_PER_PHASE) send_cmd(rand_cmd());
		cmd_valid <= 1'b0;

		// drain
		while (sb.expected_chars.size() != 0) @(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		if (sb.mismatches == 0) begin
			$display("TEST PASSED");
		end else begin
			$display("TEST FAILED");
		end
		$finish;
	end

endmodule

// ----- filelist.f -----
rtl/itf_pkg.sv
rtl/itf_step_unit.sv
rtl/itf_digit_mem.sv
rtl/integer_to_text_formatter_unit.sv
sim/integer_to_text_formatter_unit_tb.sv
